// ===== design/svrd_pkg.sv =====
// Shared types, constants and table helpers for the sine voice.
package svrd_pkg;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_NOTE_ON  = 2'd1,
    CMD_NOTE_OFF = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_MUL1,
    ST_MUL2,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;   // capture the input transaction
    logic mul1;    // sine magnitude times level
    logic mul2;    // times release factor, release factor decay product
    logic commit;  // update voice state and load the output register
  } ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_tick;   // captured command is a sample tick
    logic out_busy;  // output register full and stalled
  } status_t;

  localparam int MAG_W   = 15;            // Q15 sine magnitude
  localparam int LEVEL_W = 13;            // note level, at most 4915
  localparam int RF_W    = 17;            // Q16 release factor, up to 1.0
  localparam int PROD1_W = MAG_W + LEVEL_W;
  localparam int PROD2_W = PROD1_W + RF_W;
  localparam int RFP_W   = RF_W + 16;     // release factor times decay constant
  localparam int SUM_W   = 47;            // rounding adder, covers the Q46 case
  localparam int FRAC_PLAIN = 30;
  localparam int FRAC_REL   = 46;

  localparam logic [RF_W-1:0]  RELEASE_ONE  = 17'd65536;
  localparam logic [15:0]      RELEASE_MUL  = 16'd64881;
  localparam logic [RF_W-1:0]  RELEASE_STOP = 17'd327;
  localparam logic [RFP_W-1:0] RELEASE_HALF = 33'd32768;

  // 2^(k/12) in Q30
  localparam longint unsigned SEMITONE_Q30 [12] = '{
    64'd1073741824, 64'd1137589836, 64'd1205234447, 64'd1276901417,
    64'd1352829926, 64'd1433273380, 64'd1518500250, 64'd1608794974,
    64'd1704458901, 64'd1805811301, 64'd1913190429, 64'd2026954651
  };

  // Quarter-wave sine, Q30 angle in, Q15 magnitude out (odd Taylor series)
  function automatic logic [MAG_W-1:0] quarter_sine(input longint unsigned x);
    longint unsigned x2;
    longint unsigned p;
    longint unsigned s;
    longint unsigned q;
    x2 = (x * x) >> 30;
    p  = 64'd172272;
    p  = 64'd5026995 - ((x2 * p) >> 30);
    p  = 64'd85569306 - ((x2 * p) >> 30);
    p  = 64'd693598668 - ((x2 * p) >> 30);
    p  = 64'd1686629713 - ((x2 * p) >> 30);
    s  = (x * p) >> 30;
    q  = (s + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return q[MAG_W-1:0];
  endfunction

endpackage

// ===== design/svrd_ctrl.sv =====
// Sequencing state machine for the sine voice.
module svrd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  svrd_pkg::status_t st,
  output svrd_pkg::ctrl_t   ctrl
);

  svrd_pkg::state_t state;
  svrd_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svrd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      svrd_pkg::ST_IDLE: begin
        if (in_valid) state_next = svrd_pkg::ST_LOOKUP;
      end
      svrd_pkg::ST_LOOKUP: begin
        state_next = st.is_tick ? svrd_pkg::ST_MUL1 : svrd_pkg::ST_DONE;
      end
      svrd_pkg::ST_MUL1: state_next = svrd_pkg::ST_MUL2;
      svrd_pkg::ST_MUL2: state_next = svrd_pkg::ST_DONE;
      svrd_pkg::ST_DONE: begin
        if (!st.out_busy) state_next = svrd_pkg::ST_IDLE;
      end
      default: state_next = svrd_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl     = '0;
    in_stall = 1'b1;
    unique case (state)
      svrd_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        ctrl.latch = in_valid;
      end
      svrd_pkg::ST_LOOKUP: ;
      svrd_pkg::ST_MUL1: ctrl.mul1 = 1'b1;
      svrd_pkg::ST_MUL2: ctrl.mul2 = 1'b1;
      svrd_pkg::ST_DONE: ctrl.commit = !st.out_busy;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_to_lookup: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state == svrd_pkg::ST_LOOKUP)
    else $error("accepted transaction did not start a lookup");
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.commit |-> !st.out_busy)
    else $error("commit while output register is stalled");
  a_mul_order: assert property (@(posedge clk) disable iff (rst)
    ctrl.mul1 |=> ctrl.mul2)
    else $error("second multiply did not follow the first");
`endif

endmodule

// ===== design/svrd_dp.sv =====
// Datapath of the sine voice: ROMs, multipliers, voice state, output register.
module svrd_dp #(
  parameter int SAMPLE_RATE      = 48000,
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int SAMPLE_BITS      = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  svrd_pkg::ctrl_t               ctrl,
  output svrd_pkg::status_t             st,
  input  logic [1:0]                    command,
  input  logic [6:0]                    note_number,
  input  logic [6:0]                    note_velocity,
  input  logic                          allow_release,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] audio_sample,
  output logic                          voice_active
);

  localparam int IW = $clog2(SINE_TABLE_DEPTH);
  localparam int DW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW = PHASE_BITS + DW;
  localparam int SH_PLAIN = svrd_pkg::FRAC_PLAIN - (SAMPLE_BITS - 1);
  localparam int SH_REL   = svrd_pkg::FRAC_REL - (SAMPLE_BITS - 1);
  localparam int MW = svrd_pkg::MAG_W;
  localparam int LW = svrd_pkg::LEVEL_W;
  localparam int RW = svrd_pkg::RF_W;

  // Phase increment for a note, rounded: 440 * 2^((n-69)/12) * 2^PHASE_BITS / SAMPLE_RATE
  function automatic logic [63:0] step_calc(input int n);
    longint unsigned m;
    longint unsigned num;
    longint unsigned res;
    int e;
    int k;
    m   = 64'(n) + 64'd3;
    num = 64'd55 * svrd_pkg::SEMITONE_Q30[int'(m % 64'd12)];
    e   = int'(m / 64'd12) + PHASE_BITS - 33;
    if (e >= 0) begin
      res = ((num << e) + 64'(SAMPLE_RATE / 2)) / SAMPLE_RATE;
    end else begin
      k   = -e;
      res = ((num + (64'(SAMPLE_RATE) << (k - 1))) / SAMPLE_RATE) >> k;
    end
    return res;
  endfunction

  // Full-cycle sine entry: sign on top, Q15 magnitude below
  function automatic logic [MW:0] sine_calc(input int idx);
    int q4;
    int quad;
    int r;
    longint unsigned x;
    q4   = 4 * idx;
    quad = (q4 / SINE_TABLE_DEPTH) % 4;
    r    = q4 % SINE_TABLE_DEPTH;
    if (quad % 2 == 1) r = SINE_TABLE_DEPTH - r;
    x = (64'(r) << 30) / SINE_TABLE_DEPTH;
    return {quad >= 2, svrd_pkg::quarter_sine(x)};
  endfunction

  // Constant tables built at elaboration
  logic [PHASE_BITS-1:0] step_rom  [128];
  logic [LW-1:0]         level_rom [128];
  logic [MW:0]           sine_rom  [SINE_TABLE_DEPTH];

  for (genvar g = 0; g < 128; g++) begin : g_note
    localparam logic [63:0] STEP_VAL = step_calc(g);
    localparam logic [63:0] LVL_VAL  = (64'(g) * 64'd49152 + 64'd635) / 64'd1270;
    assign step_rom[g]  = STEP_VAL[PHASE_BITS-1:0];
    assign level_rom[g] = LVL_VAL[LW-1:0];
  end

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_sine
    localparam logic [MW:0] SINE_VAL = sine_calc(g);
    assign sine_rom[g] = SINE_VAL;
  end

  // Voice state
  logic [PHASE_BITS-1:0] phase_acc;
  logic [PHASE_BITS-1:0] phase_step;
  logic [LW-1:0]         note_level;
  logic [RW-1:0]         release_factor;
  logic                  sounding;

  // Captured transaction and pipeline registers
  svrd_pkg::cmd_t              cmd_q;
  logic [6:0]                  note_q;
  logic [6:0]                  vel_q;
  logic                        rel_q;
  logic [IW-1:0]               idx_reg;
  logic [MW:0]                 rom_q;
  logic                        neg_q;
  logic [svrd_pkg::PROD1_W-1:0] prod1;
  logic [svrd_pkg::PROD2_W-1:0] prod2;
  logic [svrd_pkg::RFP_W-1:0]   rf_prod;
  logic [SAMPLE_BITS-1:0]       sample_q;

  logic [PW-1:0] idx_prod;
  logic          releasing;

  assign releasing = (release_factor != '0);

  // Sine index from phase, then registered ROM read
  assign idx_prod = PW'(phase_acc) * PW'(SINE_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    idx_reg <= idx_prod[PHASE_BITS +: IW];
    rom_q   <= sine_rom[idx_reg];
  end

  // Input capture and multiplier stages
  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      cmd_q  <= svrd_pkg::cmd_t'(command);
      note_q <= note_number;
      vel_q  <= note_velocity;
      rel_q  <= allow_release;
    end
    if (ctrl.mul1) begin
      prod1 <= svrd_pkg::PROD1_W'(rom_q[MW-1:0]) * svrd_pkg::PROD1_W'(note_level);
      neg_q <= rom_q[MW];
    end
    if (ctrl.mul2) begin
      prod2   <= releasing ? svrd_pkg::PROD2_W'(prod1) * svrd_pkg::PROD2_W'(release_factor)
                           : svrd_pkg::PROD2_W'(prod1);
      rf_prod <= svrd_pkg::RFP_W'(release_factor) * svrd_pkg::RFP_W'(svrd_pkg::RELEASE_MUL);
    end
  end

  assign st.is_tick  = (cmd_q == svrd_pkg::CMD_TICK);
  assign st.out_busy = out_valid && out_stall;

  // Rounding of the product, symmetric about zero
  logic [svrd_pkg::SUM_W-1:0] sum_plain;
  logic [svrd_pkg::SUM_W-1:0] sum_rel;
  logic [SAMPLE_BITS-1:0]     mag_s;
  logic [svrd_pkg::RFP_W-1:0] rf_sum;
  logic [RW-1:0]              rf_decayed;

  assign sum_plain = svrd_pkg::SUM_W'(prod2) + (svrd_pkg::SUM_W'(1) << (SH_PLAIN - 1));
  assign sum_rel   = svrd_pkg::SUM_W'(prod2) + (svrd_pkg::SUM_W'(1) << (SH_REL - 1));
  assign mag_s     = releasing ? sum_rel[SH_REL +: SAMPLE_BITS]
                               : sum_plain[SH_PLAIN +: SAMPLE_BITS];
  assign rf_sum     = rf_prod + svrd_pkg::RELEASE_HALF;
  assign rf_decayed = rf_sum[16 +: RW];

  // Next voice state and sample for the captured command
  logic [PHASE_BITS-1:0]  phase_acc_next;
  logic [PHASE_BITS-1:0]  phase_step_next;
  logic [LW-1:0]          note_level_next;
  logic [RW-1:0]          release_factor_next;
  logic                   sounding_next;
  logic [SAMPLE_BITS-1:0] sample_next;

  always_comb begin
    phase_acc_next      = phase_acc;
    phase_step_next     = phase_step;
    note_level_next     = note_level;
    release_factor_next = release_factor;
    sounding_next       = sounding;
    sample_next         = '0;
    case (cmd_q)
      svrd_pkg::CMD_NOTE_ON: begin
        phase_acc_next      = '0;
        phase_step_next     = step_rom[note_q];
        note_level_next     = level_rom[vel_q];
        release_factor_next = '0;
        sounding_next       = 1'b1;
      end
      svrd_pkg::CMD_NOTE_OFF: begin
        if (rel_q) begin
          if (!releasing) release_factor_next = svrd_pkg::RELEASE_ONE;
        end else begin
          sounding_next   = 1'b0;
          phase_step_next = '0;
        end
      end
      svrd_pkg::CMD_TICK: begin
        if (sounding) begin
          sample_next    = neg_q ? (~mag_s + 1'b1) : mag_s;
          phase_acc_next = phase_acc + phase_step;
          if (releasing) begin
            release_factor_next = rf_decayed;
            if (rf_decayed <= svrd_pkg::RELEASE_STOP) begin
              sounding_next   = 1'b0;
              phase_step_next = '0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Voice state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc      <= '0;
      phase_step     <= '0;
      note_level     <= '0;
      release_factor <= '0;
      sounding       <= 1'b0;
    end else if (ctrl.commit) begin
      phase_acc      <= phase_acc_next;
      phase_step     <= phase_step_next;
      note_level     <= note_level_next;
      release_factor <= release_factor_next;
      sounding       <= sounding_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      sample_q     <= sample_next;
      voice_active <= sounding_next;
    end
  end

  assign audio_sample = sample_q;

`ifndef SYNTHESIS
  a_silent_no_step: assert property (@(posedge clk) disable iff (rst)
    !sounding |-> phase_step == '0)
    else $error("silent voice keeps a phase step");
  a_release_bound: assert property (@(posedge clk) disable iff (rst)
    release_factor <= svrd_pkg::RELEASE_ONE)
    else $error("release factor above 1.0");
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    ctrl.commit |=> out_valid)
    else $error("committed result not presented");
`endif

endmodule

// ===== design/sine_voice_with_release_decay.sv =====
// Top level of the single sine voice with exponential release.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------------
//   in      | input     | in_valid / in_stall | command, note_number, note_velocity,
//           |           |                     | allow_release
//   out     | output    | out_valid/out_stall | audio_sample, voice_active
//
// A sample tick passes through accept, the registered sine ROM read, the two
// multiplier stages (sine times level, then times release factor) and the commit;
// note on/off and the unused code go from the lookup straight to the commit.
// One transaction is in the datapath at a time; the output register holds a
// finished result, so the next transaction is taken while it waits.
// A stalled output holds the finishing transaction until the register frees.
// Synchronous reset clears the voice to silent, phase and release to zero.
module sine_voice_with_release_decay #(
  parameter int SAMPLE_RATE      = 48000,
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int SAMPLE_BITS      = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    command,
  input  logic [6:0]                    note_number,
  input  logic [6:0]                    note_velocity,
  input  logic                          allow_release,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] audio_sample,
  output logic                          voice_active
);

  svrd_pkg::ctrl_t   ctrl;
  svrd_pkg::status_t st;

  // Sequencer
  svrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .ctrl     (ctrl)
  );

  // Arithmetic, tables and voice state
  svrd_dp #(
    .SAMPLE_RATE      (SAMPLE_RATE),
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .st            (st),
    .command       (command),
    .note_number   (note_number),
    .note_velocity (note_velocity),
    .allow_release (allow_release),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .audio_sample  (audio_sample),
    .voice_active  (voice_active)
  );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the single sine voice with exponential release.
`timescale 1ns / 1ps

module testbench;

  localparam int N_ITEMS      = 1450;
  localparam int IDLE_LIMIT   = 4000;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 20;

  // Voice model constants
  localparam longint unsigned DECAY_ONE   = 64'd65536;
  localparam longint unsigned DECAY_MUL   = 64'd64881;
  localparam longint unsigned DECAY_FLOOR = 64'd327;
  localparam longint unsigned TONE_Q30 [12] = '{
    64'd1073741824, 64'd1137589836, 64'd1205234447, 64'd1276901417,
    64'd1352829926, 64'd1433273380, 64'd1518500250, 64'd1608794974,
    64'd1704458901, 64'd1805811301, 64'd1913190429, 64'd2026954651
  };

  typedef struct packed {
    logic [15:0] sample;
    logic        active;
  } voice_out_t;

  // Voice model plus queue of predicted output transactions
  class voice_scoreboard;
    bit [31:0]       phase;
    bit [31:0]       step;
    longint unsigned level;
    longint unsigned decay;
    bit              sounding;
    voice_out_t      predicted_q[$];
    int              errors;

    function void reset_voice();
      phase    = '0;
      step     = '0;
      level    = 0;
      decay    = 0;
      sounding = 1'b0;
      errors   = 0;
    endfunction

    function longint unsigned note_step(bit [6:0] note);
      int              m;
      int              sh;
      longint unsigned num;
      longint unsigned den;
      m   = int'(note) + 3;
      num = 64'd55 * TONE_Q30[m % 12];
      den = 64'd48000;
      sh  = m / 12 - 1;
      if (sh >= 0) begin
        num = num << sh;
      end else begin
        den = den << (-sh);
      end
      return ((num + den / 2) / den) & 64'hFFFF_FFFF;
    endfunction

    // Odd Taylor series to x^9, Q30 angle in, Q15 magnitude out
    function longint unsigned quarter_wave(longint unsigned x);
      longint unsigned x2;
      longint unsigned p;
      longint unsigned s;
      longint unsigned q;
      x2 = (x * x) >> 30;
      p  = 64'd172272;
      p  = 64'd5026995 - ((x2 * p) >> 30);
      p  = 64'd85569306 - ((x2 * p) >> 30);
      p  = 64'd693598668 - ((x2 * p) >> 30);
      p  = 64'd1686629713 - ((x2 * p) >> 30);
      s  = (x * p) >> 30;
      q  = (s + 64'd16384) >> 15;
      return (q > 64'd32767) ? 64'd32767 : q;
    endfunction

    function longint unsigned sine_at(bit [9:0] idx, output bit neg);
      longint unsigned q4;
      longint unsigned r;
      longint unsigned quad;
      q4   = 64'(idx) * 4;
      quad = (q4 / 1024) % 4;
      r    = q4 % 1024;
      if (quad % 2 == 1) begin
        r = 1024 - r;
      end
      neg = (quad >= 2);
      return quarter_wave((r << 30) / 1024);
    endfunction

    // Accepted input transaction: advance the voice, queue the predicted output
    function void apply_command(svrd_pkg::cmd_t cmd, bit [6:0] note, bit [6:0] vel, bit rel);
      voice_out_t      res;
      bit              neg;
      bit              releasing;
      longint unsigned mag;
      int              sh;
      res.sample = '0;
      case (cmd)
        svrd_pkg::CMD_NOTE_ON: begin
          phase    = '0;
          step     = 32'(note_step(note));
          level    = (64'(vel) * 64'd49152 + 64'd635) / 64'd1270;
          decay    = 0;
          sounding = 1'b1;
        end
        svrd_pkg::CMD_NOTE_OFF: begin
          if (rel) begin
            if (decay == 0) begin
              decay = DECAY_ONE;
            end
          end else begin
            sounding = 1'b0;
            step     = '0;
          end
        end
        svrd_pkg::CMD_TICK: begin
          if (sounding) begin
            mag       = sine_at(phase[31:22], neg) * level;
            releasing = (decay != 0);
            sh        = 15;
            if (releasing) begin
              mag = mag * decay;
              sh  = 31;
            end
            mag        = (mag + (64'd1 << (sh - 1))) >> sh;
            res.sample = neg ? 16'(-mag) : 16'(mag);
            phase      = phase + step;
            if (releasing) begin
              decay = (decay * DECAY_MUL + 64'd32768) >> 16;
              if (decay <= DECAY_FLOOR) begin
                sounding = 1'b0;
                step     = '0;
              end
            end
          end
        end
        default: ;
      endcase
      res.active = sounding;
      predicted_q.push_back(res);
    endfunction

    // Accepted output transaction against the oldest prediction
    function void compare_output(logic [15:0] sample, logic active);
      voice_out_t want;
      bit         bad;
      if (predicted_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("unexpected output transaction: audio_sample %0d voice_active %b",
                   $signed(sample), active);
        end
        return;
      end
      want = predicted_q.pop_front();
      bad  = 1'b0;
      if (sample !== want.sample) bad = 1'b1;
      if (active !== want.active) bad = 1'b1;
      if (bad) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("mismatch at %0t: audio_sample exp %0d got %0d, voice_active exp %b got %b",
                   $realtime, $signed(want.sample), $signed(sample), want.active, active);
        end
      end
    endfunction

    function int pending();
      return predicted_q.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        command = svrd_pkg::CMD_TICK;
  logic [6:0]        note_number = '0;
  logic [6:0]        note_velocity = '0;
  logic              allow_release = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [15:0] audio_sample;
  logic              voice_active;

  voice_scoreboard sb;
  int idle_pct  = 0;
  int stall_pct = 0;
  int sent      = 0;
  int quiet_cycles = 0;

  sine_voice_with_release_decay i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .note_number   (note_number),
    .note_velocity (note_velocity),
    .allow_release (allow_release),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .audio_sample  (audio_sample),
    .voice_active  (voice_active)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // Output monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.compare_output(audio_sample, voice_active);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // One input transaction, with a random gap in front of it
  task automatic drive_item(svrd_pkg::cmd_t cmd, bit [6:0] note, bit [6:0] vel, bit rel);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    note_number   <= note;
    note_velocity <= vel;
    allow_release <= rel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.apply_command(cmd, note, vel, rel);
    if (cmd != svrd_pkg::CMD_UNUSED) sent++;
  endtask

  // Sample ticks with random don't-care fields
  task automatic send_ticks(int n);
    for (int k = 0; k < n; k++) begin
      drive_item(svrd_pkg::CMD_TICK, 7'($urandom), 7'($urandom), 1'($urandom));
    end
  endtask

  task automatic send_note_on();
    drive_item(svrd_pkg::CMD_NOTE_ON, 7'($urandom), 7'($urandom), 1'($urandom));
  endtask

  initial begin
    int  sel;
    int  ph;
    bit  long_done;
    sb = new();
    sb.reset_voice();
    long_done = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: silent voice, unused code, note extremes, release corner cases
    drive_item(svrd_pkg::CMD_TICK, 7'd0, 7'd0, 1'b0);
    drive_item(svrd_pkg::CMD_UNUSED, 7'd127, 7'd127, 1'b1);
    drive_item(svrd_pkg::CMD_NOTE_OFF, 7'd0, 7'd0, 1'b1);
    drive_item(svrd_pkg::CMD_TICK, 7'd127, 7'd127, 1'b1);
    drive_item(svrd_pkg::CMD_NOTE_OFF, 7'd0, 7'd0, 1'b0);
    drive_item(svrd_pkg::CMD_NOTE_ON, 7'd0, 7'd127, 1'b0);
    send_ticks(2);
    drive_item(svrd_pkg::CMD_NOTE_ON, 7'd127, 7'd0, 1'b1);
    send_ticks(1);
    drive_item(svrd_pkg::CMD_NOTE_ON, 7'd127, 7'd127, 1'b0);
    send_ticks(2);
    drive_item(svrd_pkg::CMD_NOTE_ON, 7'd69, 7'd127, 1'b0);
    send_ticks(3);
    drive_item(svrd_pkg::CMD_UNUSED, 7'd0, 7'd0, 1'b0);
    drive_item(svrd_pkg::CMD_NOTE_OFF, 7'd0, 7'd0, 1'b1);
    send_ticks(2);
    drive_item(svrd_pkg::CMD_NOTE_OFF, 7'd0, 7'd0, 1'b1);
    send_ticks(1);
    drive_item(svrd_pkg::CMD_NOTE_OFF, 7'd0, 7'd0, 1'b0);
    send_ticks(1);

    // Random phrases across idle and back-pressure phases
    while (sent < N_ITEMS) begin
      ph = sent * 4 / N_ITEMS;
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 76; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      sel = $urandom_range(99);
      if (!long_done || sel < 2) begin
        // release followed by a long run of ticks, near or down to silence
        long_done = 1'b1;
        send_note_on();
        send_ticks($urandom_range(1, 20));
        drive_item(svrd_pkg::CMD_NOTE_OFF, 7'($urandom), 7'($urandom), 1'b1);
        send_ticks($urandom_range(520, 560));
      end else if (sel < 75) begin
        send_note_on();
        send_ticks($urandom_range(1, 30));
        sel = $urandom_range(99);
        if (sel < 65) begin
          drive_item(svrd_pkg::CMD_NOTE_OFF, 7'($urandom), 7'($urandom), 1'b1);
          send_ticks($urandom_range(0, 40));
        end else if (sel < 85) begin
          drive_item(svrd_pkg::CMD_NOTE_OFF, 7'($urandom), 7'($urandom), 1'b0);
          send_ticks($urandom_range(0, 3));
        end
      end else begin
        // noise: any command, any field values
        repeat ($urandom_range(1, 4)) begin
          drive_item(svrd_pkg::cmd_t'($urandom_range(3)), 7'($urandom), 7'($urandom),
                     1'($urandom));
        end
      end
    end
    in_valid <= 1'b0;

    // Drain and final verdict
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/svrd_pkg.sv
design/svrd_ctrl.sv
design/svrd_dp.sv
design/sine_voice_with_release_decay.sv
sim/testbench.sv
